### rtl/core/ivl_pkg.sv
// Shared types and constants of the interlace vertical low-pass filter.
package ivl_pkg;

    localparam int PIX_W   = 16;
    localparam int ROW_W   = 12;
    localparam int LINES_W = 13;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS    = 2'd0,
        MODE_LINEAR  = 2'd1,
        MODE_COMPLEX = 2'd2
    } mode_t;

    localparam logic [IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PIXEL_MAX   = 2'd2;

    localparam logic [MODE_W-1:0]  RST_FILTER_MODE = MODE_PASS;
    localparam logic [LINES_W-1:0] RST_LINE_COUNT  = 13'd1;
    localparam logic [PIX_W-1:0]   RST_PIXEL_MAX   = 16'd255;

    typedef struct packed {
        logic [MODE_W-1:0]  filter_mode;
        logic [LINES_W-1:0] line_count;
        logic [PIX_W-1:0]   pixel_max;
    } cfg_t;

    // Taps after edge-row substitution.
    typedef struct packed {
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] a2;
        logic [PIX_W-1:0] b2;
    } tap_t;

    // Partial sums of both filters.
    typedef struct packed {
        logic [PIX_W-1:0] c;
        logic [17:0]      lin;
        logic [18:0]      s3;
        logic [16:0]      neg;
        logic             up;
    } sum_t;

    // Filter results before the clip and limit step.
    typedef struct packed {
        logic [PIX_W-1:0]  c;
        logic [PIX_W-1:0]  lin_res;
        logic signed [20:0] cx;
        logic              up;
    } fin_t;

endpackage

### rtl/core/interlace_vertical_lowpass.sv
// Top level of the interlace vertical low-pass (anti-twitter) filter.
//
//   channel  direction  handshake               word
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   s        in         s_valid / s_ready       row, center and four neighbor pixels
//   m        out        m_valid / m_ready       filtered pixel
//
// Four register stages: tap substitution, partial sums, final sums, clip and limit.
// A word enters every cycle unless the pipeline stalls, and leaves after the clip and limit stage.
// Each stage holds its word while the next one is full and stalled; an empty
// stage takes a word even when the output waits, so bubbles close up.
// Synchronous active-low reset empties the pipeline and restores the registers.
// The configuration port is always ready.
module interlace_vertical_lowpass
    import ivl_pkg::*;
#(
    parameter int MAX_LINES  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ROW_W-1:0] s_row_index,
    input  logic [PIX_W-1:0] s_center_pixel,
    input  logic [PIX_W-1:0] s_above_pixel,
    input  logic [PIX_W-1:0] s_below_pixel,
    input  logic [PIX_W-1:0] s_above2_pixel,
    input  logic [PIX_W-1:0] s_below2_pixel,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_filtered_pixel
);

    cfg_t cfg;
    logic v1;
    logic r1;
    tap_t tap;
    logic v2;
    logic r2;
    sum_t sum;
    logic v3;
    logic r3;
    fin_t fin;

    ivl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ivl_edge_stage #(
        .MAX_LINES  (MAX_LINES),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_edge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .row_index    (s_row_index),
        .center_pixel (s_center_pixel),
        .above_pixel  (s_above_pixel),
        .below_pixel  (s_below_pixel),
        .above2_pixel (s_above2_pixel),
        .below2_pixel (s_below2_pixel),
        .out_valid    (v1),
        .out_ready    (r1),
        .out_tap      (tap)
    );

    ivl_sum_stage u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_tap    (tap),
        .out_valid (v2),
        .out_ready (r2),
        .out_sum   (sum)
    );

    ivl_mix_stage u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_sum    (sum),
        .out_valid (v3),
        .out_ready (r3),
        .out_fin   (fin)
    );

    ivl_limit_stage #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_limit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_fin    (fin),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_filtered_pixel)
    );

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !(v1 || v2 || v3 || m_valid))
        else $error("pipeline not empty after reset");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1)
        else $error("accepted word missing from first stage");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1 && r1) |=> v2)
        else $error("word lost between first and second stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !r3) |=> (v3 && $stable(fin)))
        else $error("stalled word changed in third stage");
`endif

endmodule

### rtl/core/ivl_cfg_regs.sv
// Configuration register file of the interlace vertical low-pass filter.
module ivl_cfg_regs
    import ivl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_mode <= RST_FILTER_MODE;
            cfg_reg.line_count  <= RST_LINE_COUNT;
            cfg_reg.pixel_max   <= RST_PIXEL_MAX;
        end else if (cfg_valid) begin
            // An index past the register list is accepted and dropped.
            unique case (cfg_index)
                CFG_FILTER_MODE: cfg_reg.filter_mode <= cfg_data[MODE_W-1:0];
                CFG_LINE_COUNT:  cfg_reg.line_count  <= cfg_data[LINES_W-1:0];
                CFG_PIXEL_MAX:   cfg_reg.pixel_max   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/ivl_edge_stage.sv
// First pipeline stage: pixel masking and edge-row tap substitution.
module ivl_edge_stage
    import ivl_pkg::*;
#(
    parameter int MAX_LINES  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ROW_W-1:0] row_index,
    input  logic [PIX_W-1:0] center_pixel,
    input  logic [PIX_W-1:0] above_pixel,
    input  logic [PIX_W-1:0] below_pixel,
    input  logic [PIX_W-1:0] above2_pixel,
    input  logic [PIX_W-1:0] below2_pixel,
    output logic             out_valid,
    input  logic             out_ready,
    output tap_t             out_tap
);

    localparam logic [PIX_W-1:0] PIX_MASK  = PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);
    localparam logic [17:0]      MAX_L_EXT = 18'(MAX_LINES);

    logic               valid_reg;
    tap_t               tap_reg;
    tap_t               tap_next;
    logic               filtering;
    logic               edge2;
    logic [LINES_W-1:0] lines;
    logic signed [14:0] bottom_thr;
    logic               top_row;
    logic               bottom_row;
    logic [PIX_W-1:0]   c;

    always_comb begin
        filtering = (cfg.filter_mode == MODE_LINEAR) || (cfg.filter_mode == MODE_COMPLEX);
        edge2     = (cfg.filter_mode == MODE_COMPLEX);
        lines     = ({5'd0, cfg.line_count} > MAX_L_EXT) ? MAX_L_EXT[LINES_W-1:0]
                                                         : cfg.line_count;
        bottom_thr = $signed({2'b00, lines}) - 15'sd1 - $signed({14'd0, edge2});
        top_row    = row_index <= {{(ROW_W-1){1'b0}}, edge2};
        // A negative threshold makes every row that is not a top row a bottom row.
        bottom_row = bottom_thr[14] || ($signed({3'b000, row_index}) >= bottom_thr);
        c          = center_pixel & PIX_MASK;

        tap_next.c  = c;
        tap_next.a  = above_pixel & PIX_MASK;
        tap_next.b  = below_pixel & PIX_MASK;
        tap_next.a2 = above2_pixel & PIX_MASK;
        tap_next.b2 = below2_pixel & PIX_MASK;
        if (filtering) begin
            if (top_row) begin
                tap_next.a  = c;
                tap_next.a2 = c;
            end else if (bottom_row) begin
                tap_next.b  = c;
                tap_next.b2 = c;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_tap   = tap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tap_reg <= tap_next;
        end
    end

endmodule

### rtl/core/ivl_sum_stage.sv
// Second pipeline stage: partial sums of the three-tap and five-tap filters.
module ivl_sum_stage
    import ivl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  tap_t in_tap,
    output logic out_valid,
    input  logic out_ready,
    output sum_t out_sum
);

    logic valid_reg;
    sum_t sum_reg;
    sum_t sum_next;

    always_comb begin
        sum_next.c   = in_tap.c;
        sum_next.lin = 18'd1 + {1'b0, in_tap.c, 1'b0} + 18'(in_tap.a) + 18'(in_tap.b);
        sum_next.s3  = 19'({in_tap.c, 1'b0}) + 19'(in_tap.c) + 19'(in_tap.a)
                     + 19'(in_tap.b);
        sum_next.neg = 17'(in_tap.a2) + 17'(in_tap.b2);
        // Direction of the limit: the near pair a and b lies above twice the center.
        sum_next.up  = (17'(in_tap.a) + 17'(in_tap.b)) > {in_tap.c, 1'b0};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_sum   = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sum_reg <= sum_next;
        end
    end

endmodule

### rtl/core/ivl_mix_stage.sv
// Third pipeline stage: final filter sums with rounding.
module ivl_mix_stage
    import ivl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sum_t in_sum,
    output logic out_valid,
    input  logic out_ready,
    output fin_t out_fin
);

    logic valid_reg;
    fin_t fin_reg;
    fin_t fin_next;

    always_comb begin
        fin_next.c       = in_sum.c;
        fin_next.lin_res = in_sum.lin[17:2];
        fin_next.cx      = 21'sd4 + $signed({1'b0, in_sum.s3, 1'b0})
                         - $signed({4'd0, in_sum.neg});
        fin_next.up      = in_sum.up;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_fin   = fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            fin_reg <= fin_next;
        end
    end

endmodule

### rtl/core/ivl_limit_stage.sv
// Output stage: clip and direction limit of the five-tap result, mode select.
module ivl_limit_stage
    import ivl_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  fin_t             in_fin,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((33'd1 << PIXEL_BITS) - 33'd1);

    logic             valid_reg;
    logic [PIX_W-1:0] pixel_reg;
    logic [PIX_W-1:0] pixel_next;
    logic [PIX_W-1:0] bound;
    logic [16:0]      shifted;
    logic [PIX_W-1:0] clipped;
    logic [PIX_W-1:0] limited;

    always_comb begin
        bound   = (cfg.pixel_max < PIX_MASK) ? cfg.pixel_max : PIX_MASK;
        shifted = in_fin.cx[20] ? 17'd0 : in_fin.cx[19:3];
        clipped = (shifted > {1'b0, bound}) ? bound : shifted[PIX_W-1:0];
        // The limit may return the center itself, even when it exceeds the clip bound.
        if (in_fin.up) begin
            limited = (clipped < in_fin.c) ? in_fin.c : clipped;
        end else begin
            limited = (clipped > in_fin.c) ? in_fin.c : clipped;
        end
        if (cfg.filter_mode == MODE_LINEAR) begin
            pixel_next = in_fin.lin_res;
        end else if (cfg.filter_mode == MODE_COMPLEX) begin
            pixel_next = limited;
        end else begin
            pixel_next = in_fin.c;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

### test/ivl_pixel_checker.sv
// Watches the configuration, pixel and result channels, predicts each filtered pixel and compares.
module ivl_pixel_checker
    import ivl_pkg::*;
#(
    parameter int FIELD_LINES_MAX = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0] cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [ROW_W-1:0] s_row_index,
    input  logic [PIX_W-1:0] s_center_pixel,
    input  logic [PIX_W-1:0] s_above_pixel,
    input  logic [PIX_W-1:0] s_below_pixel,
    input  logic [PIX_W-1:0] s_above2_pixel,
    input  logic [PIX_W-1:0] s_below2_pixel,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [PIX_W-1:0] m_filtered_pixel,
    output int               mismatches,
    output int               outstanding
);

    logic [MODE_W-1:0]  mode_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [PIX_W-1:0]   pmax_reg;
    logic [PIX_W-1:0]   expected_pixels[$];

    function automatic logic [PIX_W-1:0] lowpass_pixel(
        input logic [ROW_W-1:0] row,
        input logic [PIX_W-1:0] c_in,
        input logic [PIX_W-1:0] a_in,
        input logic [PIX_W-1:0] b_in,
        input logic [PIX_W-1:0] a2_in,
        input logic [PIX_W-1:0] b2_in
    );
        int lines;
        int edge_rows;
        int c;
        int a;
        int b;
        int a2;
        int b2;
        int acc;
        int r;
        c  = c_in;
        a  = a_in;
        b  = b_in;
        a2 = a2_in;
        b2 = b2_in;
        lines = (lines_reg > FIELD_LINES_MAX) ? FIELD_LINES_MAX : int'(lines_reg);
        edge_rows = (mode_reg == MODE_COMPLEX) ? 1 : 0;
        // Missing taps at the field edges are replaced by the center; the top rule wins.
        if (mode_reg == MODE_LINEAR || mode_reg == MODE_COMPLEX) begin
            if (int'(row) <= edge_rows) begin
                a  = c;
                a2 = c;
            end else if (int'(row) >= lines - 1 - edge_rows) begin
                b  = c;
                b2 = c;
            end
        end
        if (mode_reg == MODE_LINEAR) begin
            r = (1 + 2 * c + a + b) >>> 2;
        end else if (mode_reg == MODE_COMPLEX) begin
            acc = 4 + 2 * (3 * c + a + b) - a2 - b2;
            r = (acc < 0) ? 0 : (acc >>> 3);
            if (r > int'(pmax_reg))
                r = pmax_reg;
            // The result may not move away from the center against the trend of a and b.
            if (a + b > 2 * c) begin
                if (r < c)
                    r = c;
            end else if (r > c) begin
                r = c;
            end
        end else begin
            r = c;
        end
        return r[PIX_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    = RST_FILTER_MODE;
            lines_reg   = RST_LINE_COUNT;
            pmax_reg    = RST_PIXEL_MAX;
            mismatches  = 0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_FILTER_MODE: mode_reg  = cfg_data[MODE_W-1:0];
                    CFG_LINE_COUNT:  lines_reg = cfg_data[LINES_W-1:0];
                    CFG_PIXEL_MAX:   pmax_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_pixels.push_back(lowpass_pixel(s_row_index, s_center_pixel,
                    s_above_pixel, s_below_pixel, s_above2_pixel, s_below2_pixel));
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word: filtered_pixel %0d", m_filtered_pixel);
                    mismatches++;
                end else begin
                    if (m_filtered_pixel !== expected_pixels[0]) begin
                        if (mismatches < 10)
                            $display("filtered_pixel mismatch: expected %0d, got %0d",
                                     expected_pixels[0], m_filtered_pixel);
                        mismatches++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

### test/tb_top.sv
// Stimulus, back pressure and verdict for the interlace vertical low-pass filter.
module tb_top;
    import ivl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [IDX_W-1:0]  CFG_SPARE  = 2'd3;
    localparam int LONG_HOLD   = 80;
    localparam int ITEMS_EACH  = 110;
    localparam int NUM_SETUPS  = 12;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    logic [ROW_W-1:0] s_row_index;
    logic [PIX_W-1:0] s_center_pixel;
    logic [PIX_W-1:0] s_above_pixel;
    logic [PIX_W-1:0] s_below_pixel;
    logic [PIX_W-1:0] s_above2_pixel;
    logic [PIX_W-1:0] s_below2_pixel;
    logic             m_valid;
    logic             m_ready;
    logic [PIX_W-1:0] m_filtered_pixel;
    int               mismatches;
    int               outstanding;

    int src_idle_pct;
    int sink_idle_pct;
    int hold_requests;
    int cur_lines;
    int cur_pmax;

    interlace_vertical_lowpass DUT (.*);

    ivl_pixel_checker pixel_check (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic settle(input int extra);
        @(negedge aclk);
        s_valid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Unused upper data bits are filled at random; the block keeps only the low bits.
    task automatic apply_setup(input logic [MODE_W-1:0] mode, input int lines, input int pmax);
        settle(8);
        write_reg(CFG_FILTER_MODE, (16'($urandom) & 16'hFFFC) | 16'(mode));
        write_reg(CFG_LINE_COUNT, (16'($urandom) & 16'hE000) | 16'(lines));
        write_reg(CFG_PIXEL_MAX, 16'(pmax));
        cur_lines = lines;
        cur_pmax  = pmax;
    endtask

    task automatic push_pixel(input int row, input int c, input int a, input int b,
                              input int a2, input int b2);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_row_index    = row[ROW_W-1:0];
        s_center_pixel = c[PIX_W-1:0];
        s_above_pixel  = a[PIX_W-1:0];
        s_below_pixel  = b[PIX_W-1:0];
        s_above2_pixel = a2[PIX_W-1:0];
        s_below2_pixel = b2[PIX_W-1:0];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Rows cluster around both field edges and past the last line.
    function automatic int pick_row();
        int base;
        int r;
        base = (cur_lines > 4096) ? 4096 : cur_lines;
        case ($urandom_range(9))
            0: r = 0;
            1: r = 1;
            2: r = 2;
            3: r = base - 1 - int'($urandom_range(2));
            4: r = base + int'($urandom_range(3));
            default: r = $urandom_range(4095);
        endcase
        if (r < 0)
            r = 0;
        return r;
    endfunction

    function automatic int pick_pixel();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            2: return cur_pmax;
            3, 4: return $urandom_range(65535);
            default: return $urandom_range(cur_pmax);
        endcase
    endfunction

    initial begin
        logic [MODE_W-1:0] setup_mode[NUM_SETUPS];
        int setup_lines[NUM_SETUPS];
        int setup_pmax[NUM_SETUPS];
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_FILTER_MODE;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_row_index    = '0;
        s_center_pixel = '0;
        s_above_pixel  = '0;
        s_below_pixel  = '0;
        s_above2_pixel = '0;
        s_below2_pixel = '0;
        src_idle_pct   = 19;
        sink_idle_pct  = 83;
        hold_requests  = 0;
        cur_lines      = RST_LINE_COUNT;
        cur_pmax       = RST_PIXEL_MAX;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings pass the center through.
        push_pixel(5, 1234, 0, 65535, 7, 9);

        apply_setup(MODE_COMPLEX, 8, 255);
        write_reg(CFG_SPARE, 16'($urandom));
        push_pixel(0, 100, 200, 50, 10, 20);
        push_pixel(1, 100, 200, 50, 10, 20);
        push_pixel(2, 100, 200, 50, 10, 20);
        push_pixel(6, 100, 200, 50, 10, 20);
        push_pixel(7, 100, 200, 50, 10, 20);
        push_pixel(4095, 100, 200, 50, 10, 20);
        push_pixel(3, 0, 0, 0, 0, 0);
        push_pixel(3, 65535, 65535, 65535, 65535, 65535);
        push_pixel(3, 0, 0, 0, 65535, 65535);
        push_pixel(3, 10, 250, 250, 0, 0);
        push_pixel(3, 200, 0, 0, 255, 255);
        push_pixel(3, 1000, 2000, 2000, 0, 0);

        apply_setup(MODE_LINEAR, 8, 255);
        push_pixel(0, 100, 200, 50, 0, 0);
        push_pixel(1, 100, 200, 50, 0, 0);
        push_pixel(7, 100, 200, 50, 0, 0);
        push_pixel(3, 65535, 65535, 65535, 65535, 65535);
        push_pixel(3, 0, 0, 0, 0, 0);

        apply_setup(MODE_LINEAR, 0, 65535);
        push_pixel(0, 300, 900, 10, 0, 0);
        push_pixel(5, 300, 900, 10, 0, 0);

        apply_setup(MODE_SPARE, 8, 1);
        push_pixel(3, 4321, 1, 2, 3, 4);

        apply_setup(MODE_COMPLEX, 8191, 65535);
        push_pixel(4095, 50000, 1000, 65535, 0, 65535);
        push_pixel(4093, 50000, 1000, 65535, 0, 65535);

        setup_mode  = '{MODE_COMPLEX, MODE_LINEAR, MODE_COMPLEX, MODE_SPARE,
                        MODE_PASS, MODE_COMPLEX, MODE_LINEAR, MODE_COMPLEX,
                        MODE_COMPLEX, MODE_LINEAR, MODE_COMPLEX, MODE_COMPLEX};
        setup_lines = '{480, 1, 0, 4096, 8191, 8191, 2, 3, 4,
                        $urandom_range(1, 8191), 4096, $urandom_range(1, 16)};
        setup_pmax  = '{255, 65535, 1, 1023, 255, 65535, 100, 4095, 65535,
                        $urandom_range(1, 65535), $urandom_range(1, 65535), 255};

        for (int k = 0; k < NUM_SETUPS; k++) begin
            if (k < 4) begin
                src_idle_pct  = 19;
                sink_idle_pct = 83;
            end else if (k < 8) begin
                src_idle_pct  = 83;
                sink_idle_pct = 19;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            apply_setup(setup_mode[k], setup_lines[k], setup_pmax[k]);
            // Stall the result side while words keep coming, so the pipeline fills up.
            if (k == 8)
                hold_requests++;
            for (int n = 0; n < ITEMS_EACH; n++) begin
                if (k == 10 && n == ITEMS_EACH / 2)
                    settle(0);
                push_pixel(pick_row(), pick_pixel(), pick_pixel(), pick_pixel(),
                           pick_pixel(), pick_pixel());
            end
        end

        settle(20);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
